// File: hw/rtl/event_timer_table_core_macros.svh
// assertion macros shared by the checker
`ifndef EVENT_TIMER_TABLE_CORE_MACROS_SVH
`define EVENT_TIMER_TABLE_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ETT_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("event timer table: same-cycle check failed");

// next-cycle implication
`define ETT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("event timer table: next-cycle check failed");

`endif

// File: hw/rtl/ett_pkg.sv
package ett_pkg;

    localparam int ACTION_W = 2;
    localparam int EVENT_W  = 32;
    localparam int DUR_W    = 24;
    localparam int DATA_W   = 32;
    localparam int STEP_W   = 16;
    localparam int SLOT_W   = 4;
    localparam int KIND_W   = 2;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd100;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET     = 2'd0,
        ACT_RESTART = 2'd1,
        ACT_DELETE  = 2'd2,
        ACT_TICK    = 2'd3
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET_DONE  = 2'd0,
        KIND_DEL_DONE  = 2'd1,
        KIND_EXPIRED   = 2'd2,
        KIND_TICK_DONE = 2'd3
    } t_kind;

    // one slot of the timer memory
    typedef struct packed {
        logic [DUR_W-1:0]   remaining;
        logic [EVENT_W-1:0] event_id;
        logic [DATA_W-1:0]  user_data;
    } t_slot_word;

    localparam int SLOT_WORD_W = $bits(t_slot_word);

    // verdict of the slot evaluator on the slot under scan
    typedef struct packed {
        logic             hit;
        logic             live;
        logic [DUR_W-1:0] rem_next;
    } t_eval;

    typedef struct packed {
        t_kind              kind;
        logic               ok;
        logic [SLOT_W-1:0]  slot;
        logic [EVENT_W-1:0] expired_event;
        logic [DATA_W-1:0]  expired_data;
        logic               last;
    } t_result;

endpackage

// File: hw/rtl/ett_ram.sv
module ett_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hw/rtl/ett_slot_eval.sv
module ett_slot_eval (
    input  ett_pkg::t_slot_word                i_word,
    input  logic                               i_busy,
    input  logic [ett_pkg::EVENT_W-1:0]        i_event,
    input  logic [ett_pkg::STEP_W-1:0]         i_step,
    output ett_pkg::t_eval                     o_eval
);

    logic [ett_pkg::DUR_W-1:0] step_ext;

    assign step_ext = ett_pkg::DUR_W'(i_step);

    always_comb begin
        o_eval.hit      = i_busy && (i_word.event_id == i_event);
        o_eval.live     = i_word.remaining > step_ext;
        o_eval.rem_next = i_word.remaining - step_ext;
    end

endmodule

// File: hw/rtl/event_timer_table_core.sv
// channel   direction  handshake                       payload
// command   in         start high while busy low       i_action i_event_id i_duration i_user_data
// result    out        o_strobe, one cycle, no stall   o_kind o_ok o_slot o_expired_event
//                                                      o_expired_data o_last
// config    in         i_cfg_valid and o_cfg_ready     i_cfg_data (tick step)
//
// an item scans the slots one per cycle through the single read port of the slot
// memory; set stops at the first idle slot, restart at the first live match and
// delete at the first match, and a tick visits every slot before tick done.
// busy is high from the cycle after acceptance until the final result is shown.
// reset clears the busy bits and control and loads a tick step of 100; slot contents
// are not cleared. results cannot be held off: one strobe per result, at most one a cycle.
module event_timer_table_core #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ett_pkg::ACTION_W-1:0] i_action,
    input  logic [ett_pkg::EVENT_W-1:0]  i_event_id,
    input  logic [ett_pkg::DUR_W-1:0]    i_duration,
    input  logic [ett_pkg::DATA_W-1:0]   i_user_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ett_pkg::STEP_W-1:0]   i_cfg_data,
    output logic                         o_strobe,
    output logic [ett_pkg::KIND_W-1:0]   o_kind,
    output logic                         o_ok,
    output logic [ett_pkg::SLOT_W-1:0]   o_slot,
    output logic [ett_pkg::EVENT_W-1:0]  o_expired_event,
    output logic [ett_pkg::DATA_W-1:0]   o_expired_data,
    output logic                         o_last
);

    localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                       r_state, n_state;
    ett_pkg::t_action             r_action, n_action;
    logic [ett_pkg::EVENT_W-1:0]  r_event, n_event;
    logic [ett_pkg::DUR_W-1:0]    r_duration, n_duration;
    logic [ett_pkg::DATA_W-1:0]   r_data, n_data;
    logic [ett_pkg::STEP_W-1:0]   r_step, n_step;
    logic [NUM_SLOTS-1:0]         r_busy, n_busy;
    logic [IDXW-1:0]              r_rd_idx, n_rd_idx;
    logic                         r_rd_more, n_rd_more;
    logic [IDXW-1:0]              r_ev_idx, n_ev_idx;
    logic                         r_ev_vld, n_ev_vld;
    logic                         r_have_free, n_have_free;
    logic [IDXW-1:0]              r_free_idx, n_free_idx;
    logic                         r_strobe, n_strobe;
    ett_pkg::t_result             r_res, n_res;

    logic                         ram_we;
    logic [IDXW-1:0]              ram_waddr;
    ett_pkg::t_slot_word          ram_wdata;
    ett_pkg::t_slot_word          rd_word;
    logic [ett_pkg::SLOT_WORD_W-1:0] rd_bits;
    logic                         ev_busy;
    ett_pkg::t_eval               ev;

    function automatic ett_pkg::t_result make_result(
        input ett_pkg::t_kind              kind,
        input logic                        ok,
        input logic [IDXW-1:0]             idx,
        input logic [ett_pkg::EVENT_W-1:0] xev,
        input logic [ett_pkg::DATA_W-1:0]  xdata,
        input logic                        last
    );
        ett_pkg::t_result res;
        res.kind          = kind;
        res.ok            = ok;
        res.slot          = ett_pkg::SLOT_W'(idx);
        res.expired_event = xev;
        res.expired_data  = xdata;
        res.last          = last;
        return res;
    endfunction

    ett_ram #(
        .WIDTH (ett_pkg::SLOT_WORD_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_bits)
    );

    assign rd_word = rd_bits;
    assign ev_busy = r_busy[r_ev_idx];

    ett_slot_eval u_slot_eval (
        .i_word  (rd_word),
        .i_busy  (ev_busy),
        .i_event (r_event),
        .i_step  (r_step),
        .o_eval  (ev)
    );

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_event     = r_event;
        n_duration  = r_duration;
        n_data      = r_data;
        n_step      = r_step;
        n_busy      = r_busy;
        n_rd_idx    = r_rd_idx;
        n_rd_more   = r_rd_more;
        n_ev_idx    = r_ev_idx;
        n_ev_vld    = r_ev_vld;
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_strobe    = 1'b0;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_ev_idx;
        ram_wdata   = rd_word;

        if (i_cfg_valid && o_cfg_ready) begin
            n_step = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_action    = ett_pkg::t_action'(i_action);
                    n_event     = i_event_id;
                    n_duration  = i_duration;
                    // plain set arms with a zero data word
                    n_data      = (ett_pkg::t_action'(i_action) == ett_pkg::ACT_SET) ?
                                  '0 : i_user_data;
                    n_rd_idx    = '0;
                    n_rd_more   = 1'b1;
                    n_ev_vld    = 1'b0;
                    n_have_free = 1'b0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // read side runs one slot ahead of the evaluator
                n_ev_vld = r_rd_more;
                if (r_rd_more) begin
                    n_ev_idx = r_rd_idx;
                    if (r_rd_idx == LAST_IDX) begin
                        n_rd_more = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
                if (r_ev_vld) begin
                    unique case (r_action)
                        ett_pkg::ACT_SET: begin
                            if (!ev_busy) begin
                                ram_we           = 1'b1;
                                ram_wdata        = '{r_duration, r_event, r_data};
                                n_busy[r_ev_idx] = 1'b1;
                                n_strobe         = 1'b1;
                                n_res = make_result(ett_pkg::KIND_SET_DONE, 1'b1,
                                                    r_ev_idx, '0, '0, 1'b1);
                                n_state          = S_IDLE;
                            end
                        end
                        ett_pkg::ACT_RESTART: begin
                            if (ev.hit && ev.live) begin
                                ram_we    = 1'b1;
                                ram_wdata = '{r_duration, rd_word.event_id,
                                              rd_word.user_data};
                                n_strobe  = 1'b1;
                                n_res = make_result(ett_pkg::KIND_SET_DONE, 1'b1,
                                                    r_ev_idx, '0, '0, 1'b1);
                                n_state   = S_IDLE;
                            end else if (!ev_busy && !r_have_free) begin
                                n_have_free = 1'b1;
                                n_free_idx  = r_ev_idx;
                            end
                        end
                        ett_pkg::ACT_DELETE: begin
                            if (ev.hit) begin
                                n_busy[r_ev_idx] = 1'b0;
                                n_strobe         = 1'b1;
                                n_res = make_result(ett_pkg::KIND_DEL_DONE, 1'b1,
                                                    r_ev_idx, '0, '0, 1'b1);
                                n_state          = S_IDLE;
                            end
                        end
                        ett_pkg::ACT_TICK: begin
                            if (ev_busy) begin
                                if (ev.live) begin
                                    ram_we    = 1'b1;
                                    ram_wdata = '{ev.rem_next, rd_word.event_id,
                                                  rd_word.user_data};
                                end else begin
                                    n_busy[r_ev_idx] = 1'b0;
                                    n_strobe         = 1'b1;
                                    n_res = make_result(ett_pkg::KIND_EXPIRED, 1'b0,
                                                        r_ev_idx, rd_word.event_id,
                                                        rd_word.user_data, 1'b0);
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (r_ev_idx == LAST_IDX && n_state == S_SCAN) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                unique case (r_action)
                    ett_pkg::ACT_SET: begin
                        n_res = make_result(ett_pkg::KIND_SET_DONE, 1'b0, '0, '0, '0, 1'b1);
                    end
                    ett_pkg::ACT_RESTART: begin
                        // no live match: allocate the lowest idle slot seen in the scan
                        if (r_have_free) begin
                            ram_we             = 1'b1;
                            ram_waddr          = r_free_idx;
                            ram_wdata          = '{r_duration, r_event, r_data};
                            n_busy[r_free_idx] = 1'b1;
                            n_res = make_result(ett_pkg::KIND_SET_DONE, 1'b1,
                                                r_free_idx, '0, '0, 1'b1);
                        end else begin
                            n_res = make_result(ett_pkg::KIND_SET_DONE, 1'b0,
                                                '0, '0, '0, 1'b1);
                        end
                    end
                    ett_pkg::ACT_DELETE: begin
                        n_res = make_result(ett_pkg::KIND_DEL_DONE, 1'b0, '0, '0, '0, 1'b1);
                    end
                    ett_pkg::ACT_TICK: begin
                        n_res = make_result(ett_pkg::KIND_TICK_DONE, 1'b0, '0, '0, '0, 1'b1);
                    end
                    default: ;
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_event    <= n_event;
        r_duration <= n_duration;
        r_data     <= n_data;
        r_rd_idx   <= n_rd_idx;
        r_ev_idx   <= n_ev_idx;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ett_pkg::STEP_RESET;
            r_busy      <= '0;
            r_rd_more   <= 1'b0;
            r_ev_vld    <= 1'b0;
            r_have_free <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_busy      <= n_busy;
            r_rd_more   <= n_rd_more;
            r_ev_vld    <= n_ev_vld;
            r_have_free <= n_have_free;
            r_strobe    <= n_strobe;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_kind          = r_res.kind;
    assign o_ok            = r_res.ok;
    assign o_slot          = r_res.slot;
    assign o_expired_event = r_res.expired_event;
    assign o_expired_data  = r_res.expired_data;
    assign o_last          = r_res.last;

endmodule

// File: hw/rtl/ett_checker.sv
`include "event_timer_table_core_macros.svh"

module ett_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_strobe,
    input logic [ett_pkg::KIND_W-1:0]   o_kind,
    input logic                         o_ok,
    input logic                         o_last
);

    // an accepted item keeps the block busy until its final result
    `ETT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // the final result releases the block in the same cycle
    `ETT_ASSERT_IMPL(a_last_frees, o_strobe && o_last, !busy)
    // expiries only come in the middle of a tick
    `ETT_ASSERT_IMPL(a_expiry_mid, o_strobe && o_kind == ett_pkg::KIND_EXPIRED, busy && !o_ok && !o_last)
    // a result only follows a cycle spent on an item
    `ETT_ASSERT_IMPL(a_strobe_after_work, o_strobe, $past(busy))

endmodule

bind event_timer_table_core ett_checker u_ett_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_kind   (o_kind),
    .o_ok     (o_ok),
    .o_last   (o_last)
);
